FILE: hw/rtl/rsbm_pkg.sv
`default_nettype none

package rsbm_pkg;

	// Store depths and the address widths that follow from them.
	localparam int ROM_DEPTH  = 4194304;
	localparam int SRAM_DEPTH = 131072;
	localparam int ROM_AW     = $clog2(ROM_DEPTH);
	localparam int SRAM_AW    = $clog2(SRAM_DEPTH);

	// Field widths.
	localparam int ADDR_W     = 24;
	localparam int IDX_W      = 23;
	localparam int SRAM_SZ_W  = 18;
	localparam int CFG_W      = 23;
	localparam int CFG_IDX_W  = 2;

	// Remainder unit: MOD_BITS dividend bits retired per cycle.
	localparam int MOD_BITS   = 3;
	localparam int MOD_STEPS  = 8;
	localparam int NUM_W      = MOD_BITS * MOD_STEPS;
	localparam int STEP_W     = $clog2(MOD_STEPS);

	// Item modes.
	localparam logic [1:0] MODE_READ    = 2'd0;
	localparam logic [1:0] MODE_WRITE   = 2'd1;
	localparam logic [1:0] MODE_PRELOAD = 2'd2;

	// Result targets.
	localparam logic [1:0] TGT_NONE = 2'd0;
	localparam logic [1:0] TGT_ROM  = 2'd1;
	localparam logic [1:0] TGT_RAM  = 2'd2;

	// Mapper layouts.
	localparam logic [1:0] LAYOUT_LOW  = 2'd0;
	localparam logic [1:0] LAYOUT_HIGH = 2'd1;
	localparam logic [1:0] LAYOUT_EXT  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOADED    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROM_SIZE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SRAM_SIZE = 2'd3;

	// Bank and offset window bounds.
	localparam logic [6:0]  BANK_LO_RAM_FIRST = 7'h70;
	localparam logic [6:0]  BANK_LO_RAM_LAST  = 7'h7D;
	localparam logic [6:0]  BANK_HI_RAM_FIRST = 7'h20;
	localparam logic [6:0]  BANK_HI_RAM_LAST  = 7'h3F;
	localparam logic [6:0]  BANK_ROM_FIRST    = 7'h40;
	localparam logic [6:0]  BANK_ROM_LAST     = 7'h7D;
	localparam logic [7:0]  BANK_EXT_FIRST    = 8'hC0;
	localparam logic [15:0] OFF_UPPER         = 16'h8000;
	localparam logic [15:0] OFF_HI_RAM_FIRST  = 16'h6000;
	localparam logic [IDX_W-1:0] ROM_LO_UPPER_BASE = 23'h200000;

	typedef struct packed {
		logic [1:0]        mode;
		logic [ADDR_W-1:0] address;
		logic [7:0]        write_data;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [1:0] target;
	} result_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic decode;
		logic mod_step;
		logic access;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic need_mod;
	} status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rom_sram_bank_mapper.sv
// Cartridge bank address mapper. Each transaction on the item channel is a bus
// read, a bus write or a ROM preload byte; each one produces exactly one
// transaction on the result channel carrying the byte read and the decoded
// target (none, ROM or battery RAM). The configuration port selects the layout
// (low-bank, high-bank or extended high-bank) and the ROM and battery RAM sizes
// used for mirroring, and must only be written while no transaction is in
// flight. Items are handled one at a time. A ROM read, or a battery RAM read or
// write, that reaches a store with a nonzero size passes from acceptance to the
// next acceptance through decode, the shared remainder unit that retires three
// index bits per cycle to wrap the index by the configured size, one registered
// memory access, the result load and the idle state in which the next item is
// taken. All other items (preloads, ROM writes, unmapped addresses, empty
// stores, no cartridge, the spare mode) go from decode straight to the result
// load. A result that has not yet been taken holds the next one in its result
// load state, and no new item is accepted until it moves. After reset the
// battery RAM is swept to zero one byte per cycle over its whole depth, and no
// item is accepted until that pass ends; configuration writes are taken
// throughout. ROM contents are undefined until preloaded.
`default_nettype none

module rom_sram_bank_mapper (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           item_valid,
	output logic                                item_ready,
	input  wire rsbm_pkg::item_t                item,
	output logic                                result_valid,
	input  wire logic                           result_ready,
	output rsbm_pkg::result_t                   result,
	input  wire logic                           cfg_we,
	input  wire logic [rsbm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rsbm_pkg::CFG_W-1:0]     cfg_data
);
	import rsbm_pkg::*;

	// Commands from the sequencer and status back from the datapath.
	cmd_t    cmd;
	status_t status;

	// The sequencer owns the handshakes and the result valid flag; the
	// datapath holds the item, configuration, remainder unit and both stores.
	rsbm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.cmd          (cmd)
	);

	rsbm_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/rsbm_ctrl.sv
`default_nettype none

module rsbm_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            item_valid,
	output logic                 item_ready,
	output logic                 result_valid,
	input  wire logic            result_ready,
	input  wire rsbm_pkg::status_t status,
	output rsbm_pkg::cmd_t       cmd
);
	import rsbm_pkg::*;

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_DECODE = 3'd2;
	localparam logic [2:0] ST_MOD    = 3'd3;
	localparam logic [2:0] ST_ACCESS = 3'd4;
	localparam logic [2:0] ST_FINISH = 3'd5;

	logic [2:0]        state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              out_free;

	assign out_free     = !out_valid_q || result_ready;
	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.decode = 1'b1;
				state_d    = status.need_mod ? ST_MOD : ST_FINISH;
			end
			ST_MOD: begin
				cmd.mod_step = 1'b1;
				if (step_q == STEP_W'(MOD_STEPS - 1)) begin
					state_d = ST_ACCESS;
				end
			end
			ST_ACCESS: begin
				cmd.access = 1'b1;
				state_d    = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.mod_step) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/rsbm_datapath.sv
`default_nettype none

module rsbm_datapath (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire rsbm_pkg::item_t                item,
	output rsbm_pkg::result_t                   result,
	input  wire logic                           cfg_we,
	input  wire logic [rsbm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rsbm_pkg::CFG_W-1:0]     cfg_data,
	input  wire rsbm_pkg::cmd_t                 cmd,
	output rsbm_pkg::status_t                   status
);
	import rsbm_pkg::*;

	// Configuration registers.
	logic [1:0]           layout_q;
	logic                 loaded_q;
	logic [IDX_W-1:0]     rom_size_q;
	logic [SRAM_SZ_W-1:0] sram_size_q;

	// Item, decode results and remainder unit.
	item_t            item_q;
	logic [1:0]       tgt_q;
	logic [1:0]       rd_sel_q;
	logic [NUM_W-1:0] num_q;
	logic [IDX_W-1:0] rem_q;
	logic [IDX_W-1:0] div_q;
	logic [SRAM_AW-1:0] clr_q;
	result_t          result_q;

	// Stores.
	logic [7:0] rom_mem [ROM_DEPTH];
	logic [7:0] sram_mem [SRAM_DEPTH];
	logic [7:0] rom_rd_q;
	logic [7:0] sram_rd_q;

	logic [7:0]       bank;
	logic [15:0]      off;
	logic [6:0]       eb;
	logic             high_map;
	logic [1:0]       dec_tgt;
	logic [IDX_W-1:0] dec_idx;
	logic             is_bus;
	logic             preload_ok;
	logic [1:0]       res_tgt;
	logic [IDX_W-1:0] divisor;
	logic [NUM_W-1:0] num_next;
	logic [IDX_W-1:0] rem_next;
	logic             rom_in_range;
	logic             sram_in_range;
	logic             rom_rd_en;
	logic             sram_rd_en;
	logic             sram_we;
	logic [SRAM_AW-1:0] sram_waddr;
	logic [7:0]       sram_wdata;

	// Bank/offset decode of the held item.
	always_comb begin
		bank     = item_q.address[ADDR_W-1:16];
		off      = item_q.address[15:0];
		eb       = bank[6:0];
		high_map = (layout_q == LAYOUT_HIGH) || (layout_q == LAYOUT_EXT);
		dec_tgt  = TGT_NONE;
		dec_idx  = '0;
		if (high_map) begin
			if (eb >= BANK_HI_RAM_FIRST && eb <= BANK_HI_RAM_LAST &&
			    off >= OFF_HI_RAM_FIRST && off < OFF_UPPER) begin
				dec_tgt = TGT_RAM;
				dec_idx = IDX_W'({eb[4:0], off[12:0]});
			end else if (eb >= BANK_ROM_FIRST && eb <= BANK_ROM_LAST) begin
				dec_tgt = TGT_ROM;
				if (layout_q == LAYOUT_EXT && bank >= BANK_EXT_FIRST) begin
					dec_idx = {1'b1, bank[5:0], off};
				end else begin
					dec_idx = {1'b0, eb[5:0], off};
				end
			end else if (eb <= BANK_HI_RAM_LAST && off >= OFF_UPPER) begin
				dec_tgt = TGT_ROM;
				dec_idx = {1'b0, eb[5:0], off};
			end
		end else begin
			if (eb >= BANK_LO_RAM_FIRST && eb <= BANK_LO_RAM_LAST && off < OFF_UPPER) begin
				dec_tgt = TGT_RAM;
				dec_idx = IDX_W'({eb[3:0], off[14:0]});
			end else if (off >= OFF_UPPER) begin
				dec_tgt = TGT_ROM;
				dec_idx = IDX_W'({eb, off[14:0]});
			end else if (eb >= BANK_ROM_FIRST) begin
				dec_tgt = TGT_ROM;
				dec_idx = {1'b0, eb[5:0], off} + ROM_LO_UPPER_BASE;
			end
		end
	end

	assign is_bus     = loaded_q &&
	                    (item_q.mode == MODE_READ || item_q.mode == MODE_WRITE);
	assign preload_ok = (item_q.mode == MODE_PRELOAD) &&
	                    (item_q.address < ADDR_W'(ROM_DEPTH));
	assign res_tgt    = is_bus ? dec_tgt : (preload_ok ? TGT_ROM : TGT_NONE);
	assign divisor    = (dec_tgt == TGT_RAM) ? IDX_W'(sram_size_q) : rom_size_q;

	assign status.need_mod = is_bus &&
	                         ((dec_tgt == TGT_RAM && sram_size_q != '0) ||
	                          (dec_tgt == TGT_ROM && rom_size_q != '0 &&
	                           item_q.mode == MODE_READ));
	assign status.clear_last = (clr_q == SRAM_AW'(SRAM_DEPTH - 1));

	// Restoring remainder, MOD_BITS dividend bits per cycle.
	always_comb begin
		logic [IDX_W:0]   t;
		logic [IDX_W-1:0] r;
		logic [NUM_W-1:0] n;
		r = rem_q;
		n = num_q;
		for (int k = 0; k < MOD_BITS; k++) begin
			t = {r, n[NUM_W-1]};
			n = {n[NUM_W-2:0], 1'b0};
			if (t >= {1'b0, div_q}) begin
				t = t - {1'b0, div_q};
			end
			r = t[IDX_W-1:0];
		end
		rem_next = r;
		num_next = n;
	end

	assign rom_in_range  = ({1'b0, rem_q} < (IDX_W + 1)'(ROM_DEPTH));
	assign sram_in_range = ({1'b0, rem_q} < (IDX_W + 1)'(SRAM_DEPTH));
	assign rom_rd_en     = cmd.access && tgt_q == TGT_ROM && rom_in_range;
	assign sram_rd_en    = cmd.access && tgt_q == TGT_RAM && sram_in_range &&
	                       item_q.mode == MODE_READ;
	assign sram_we       = cmd.clear || (cmd.access && tgt_q == TGT_RAM &&
	                       sram_in_range && item_q.mode == MODE_WRITE);
	assign sram_waddr    = cmd.clear ? clr_q : rem_q[SRAM_AW-1:0];
	assign sram_wdata    = cmd.clear ? 8'd0 : item_q.write_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_q    <= LAYOUT_LOW;
			loaded_q    <= 1'b0;
			rom_size_q  <= '0;
			sram_size_q <= '0;
			clr_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_LAYOUT:    layout_q    <= cfg_data[1:0];
					CFG_LOADED:    loaded_q    <= cfg_data[0];
					CFG_ROM_SIZE:  rom_size_q  <= cfg_data[IDX_W-1:0];
					CFG_SRAM_SIZE: sram_size_q <= cfg_data[SRAM_SZ_W-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.clear) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.decode) begin
			tgt_q    <= res_tgt;
			num_q    <= NUM_W'(dec_idx);
			rem_q    <= '0;
			div_q    <= divisor;
			rd_sel_q <= TGT_NONE;
		end
		if (cmd.mod_step) begin
			num_q <= num_next;
			rem_q <= rem_next;
		end
		if (cmd.access) begin
			if (rom_rd_en) begin
				rd_sel_q <= TGT_ROM;
			end else if (sram_rd_en) begin
				rd_sel_q <= TGT_RAM;
			end
		end
		if (cmd.finish) begin
			result_q.target <= tgt_q;
			case (rd_sel_q)
				TGT_ROM: result_q.read_data <= rom_rd_q;
				TGT_RAM: result_q.read_data <= sram_rd_q;
				default: result_q.read_data <= 8'd0;
			endcase
		end
	end

	// ROM: preload writes during decode, reads during access.
	always_ff @(posedge clk) begin
		if (cmd.decode && preload_ok) begin
			rom_mem[item_q.address[ROM_AW-1:0]] <= item_q.write_data;
		end
		if (rom_rd_en) begin
			rom_rd_q <= rom_mem[rem_q[ROM_AW-1:0]];
		end
	end

	// Battery RAM: clearing sweep or bus write, and bus read.
	always_ff @(posedge clk) begin
		if (sram_we) begin
			sram_mem[sram_waddr] <= sram_wdata;
		end
		if (sram_rd_en) begin
			sram_rd_q <= sram_mem[rem_q[SRAM_AW-1:0]];
		end
	end

	assign result = result_q;

endmodule

`default_nettype wire

FILE: tb/rom_sram_bank_mapper_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the cartridge bank address mapper.
// A behavioral copy of the mapper runs beside the block: every transaction
// accepted on the item channel is pushed through it at the acceptance edge,
// and the reply it produces is queued. Each transaction on the result channel
// is compared field by field against the oldest queued reply.
module rom_sram_bank_mapper_test;
	import rsbm_pkg::*;

	// Codes the block defines but never names: the spare mode and layout.
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [1:0] LAYOUT_LOW_ALIAS = 2'd3;

	// Timing bounds. The limit covers the RAM sweep after reset plus every access at
	// its slowest with the longest stalls, several times.
	localparam int unsigned LIMIT_CYCLES = 1500000;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned HOLD_OFF_CYCLES = 300;
	localparam int unsigned ITEMS_PER_SETUP = 34;

	// Bank and offset values that sit on window boundaries.
	localparam logic [13*8-1:0] CORNER_BANKS = {8'h00, 8'h1F, 8'h20, 8'h3F, 8'h40,
		8'h6F, 8'h70, 8'h7D, 8'h7E, 8'h7F, 8'hC0, 8'hFD, 8'hFF};
	localparam logic [6*16-1:0] CORNER_OFFSETS = {16'h0000, 16'h5FFF, 16'h6000,
		16'h7FFF, 16'h8000, 16'hFFFF};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	// Behavioral copy of the mapper: its registers and both stores. The ROM
	// image only holds bytes that were preloaded, so a read of a hole can be
	// spotted and filled before it is sent.
	logic [1:0] layout_cfg = LAYOUT_LOW;
	logic loaded_cfg = 1'b0;
	logic [22:0] rom_size_cfg = '0;
	logic [17:0] sram_size_cfg = '0;
	logic [7:0] rom_image [int unsigned];
	logic [7:0] sram_image [SRAM_DEPTH];

	// Replies owed by the block, oldest first.
	result_t due_replies [$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;

	// Idle rates in percent for each side, and the hold-off handshake between
	// the stimulus and the receiver: bumping hold_off_asks starts one long stall.
	int unsigned send_idle_pct = 37;
	int unsigned recv_idle_pct = 81;
	int unsigned hold_off_asks = 0;
	int unsigned hold_off_seen = 0;
	int unsigned hold_off_left = 0;

	rom_sram_bank_mapper u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// Run limit. A hung handshake ends up here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("rom_sram_bank_mapper_test failed");
			$finish;
		end
	end

	// Decode a bus address under the current layout. Returns the window and
	// the index into it before any wrapping by the configured size.
	function automatic logic [1:0] decode_bus(input logic [23:0] addr,
			output int unsigned idx);
		int unsigned bank;
		int unsigned off;
		int unsigned eb;
		bank = 32'(addr[23:16]);
		off = 32'(addr[15:0]);
		eb = bank & 'h7F;
		idx = 0;
		if (layout_cfg == LAYOUT_HIGH || layout_cfg == LAYOUT_EXT) begin
			if (eb >= 'h20 && eb <= 'h3F && off >= 'h6000 && off < 'h8000) begin
				idx = (eb - 'h20) * 'h2000 + (off - 'h6000);
				return TGT_RAM;
			end
			if (eb >= 'h40 && eb <= 'h7D) begin
				// The extended layout puts banks C0 and up above 4MB.
				if (layout_cfg == LAYOUT_EXT && bank >= 'hC0)
					idx = (bank - 'hC0) * 'h10000 + off + 'h400000;
				else
					idx = (eb - 'h40) * 'h10000 + off;
				return TGT_ROM;
			end
			if (eb <= 'h3F && off >= 'h8000) begin
				idx = eb * 'h10000 + off;
				return TGT_ROM;
			end
			return TGT_NONE;
		end
		// Low-bank layout; the spare layout code decodes the same way.
		if (eb >= 'h70 && eb <= 'h7D && off < 'h8000) begin
			idx = (eb - 'h70) * 'h8000 + off;
			return TGT_RAM;
		end
		if (off >= 'h8000) begin
			idx = eb * 'h8000 + (off - 'h8000);
			return TGT_ROM;
		end
		if (eb >= 'h40) begin
			idx = (eb - 'h40) * 'h10000 + off + 'h200000;
			return TGT_ROM;
		end
		return TGT_NONE;
	endfunction

	// Apply one access to the behavioral stores and return the reply it owes.
	function automatic result_t apply_access(input item_t it);
		result_t reply;
		int unsigned idx;
		logic [1:0] window;
		reply = '0;
		case (it.mode)
			MODE_PRELOAD: begin
				if (32'(it.address) < ROM_DEPTH) begin
					rom_image[32'(it.address)] = it.write_data;
					reply.target = TGT_ROM;
				end
			end
			MODE_READ, MODE_WRITE: begin
				if (loaded_cfg) begin
					window = decode_bus(it.address, idx);
					reply.target = window;
					if (window == TGT_RAM && sram_size_cfg != 0) begin
						idx = idx % 32'(sram_size_cfg);
						// A wrapped index past the RAM depth reads 0 and drops writes.
						if (idx < SRAM_DEPTH) begin
							if (it.mode == MODE_READ)
								reply.read_data = sram_image[idx];
							else
								sram_image[idx] = it.write_data;
						end
					end else if (window == TGT_ROM && rom_size_cfg != 0 &&
							it.mode == MODE_READ) begin
						idx = idx % 32'(rom_size_cfg);
						if (idx < ROM_DEPTH && rom_image.exists(idx))
							reply.read_data = rom_image[idx];
					end
				end
			end
			default: ;
		endcase
		return reply;
	endfunction

	// True when the item is a read that would fetch a real ROM byte; idx then
	// holds the wrapped ROM index.
	function automatic bit reads_rom_byte(input item_t it, output int unsigned idx);
		idx = 0;
		if (it.mode != MODE_READ || !loaded_cfg || rom_size_cfg == 0)
			return 1'b0;
		if (decode_bus(it.address, idx) != TGT_ROM)
			return 1'b0;
		idx = idx % 32'(rom_size_cfg);
		return idx < ROM_DEPTH;
	endfunction

	function automatic item_t bus_item(input logic [1:0] mode, input logic [23:0] addr,
			input logic [7:0] data);
		item_t it;
		it.mode = mode;
		it.address = addr;
		it.write_data = data;
		return it;
	endfunction

	// Bus addresses: a quarter fully random, the rest aimed at the RAM window
	// of the current layout, the upper-offset ROM area and the window corners.
	function automatic logic [23:0] rand_bus_address();
		logic [7:0] bank;
		logic [15:0] off;
		logic [23:0] anywhere;
		anywhere = 24'($urandom);
		bank = anywhere[23:16];
		off = anywhere[15:0];
		case ($urandom_range(3))
			0: ;
			1: begin
				if (layout_cfg == LAYOUT_HIGH || layout_cfg == LAYOUT_EXT) begin
					bank = 8'h20 + 8'($urandom_range(31));
					off = 16'h6000 + 16'($urandom_range(16'h1FFF));
				end else begin
					bank = 8'h70 + 8'($urandom_range(13));
					off = 16'($urandom_range(16'h7FFF));
				end
				bank[7] = 1'($urandom_range(1));
			end
			2: off[15] = 1'b1;
			default: begin
				bank = CORNER_BANKS[8*$urandom_range(12) +: 8];
				off = CORNER_OFFSETS[16*$urandom_range(5) +: 16];
			end
		endcase
		return {bank, off};
	endfunction

	// Mostly reads and writes, a fifth preloads, a few spare-mode items.
	// Half the preloads land inside the configured ROM size so later reads
	// find mirrored bytes.
	function automatic item_t rand_item();
		item_t it;
		int unsigned pick;
		int unsigned span;
		pick = $urandom_range(99);
		it.write_data = 8'($urandom);
		it.address = rand_bus_address();
		if (pick < 45) begin
			it.mode = MODE_READ;
		end else if (pick < 75) begin
			it.mode = MODE_WRITE;
		end else if (pick < 96) begin
			it.mode = MODE_PRELOAD;
			if (rom_size_cfg != 0 && 32'(rom_size_cfg) <= ROM_DEPTH)
				span = 32'(rom_size_cfg);
			else
				span = 'h10000;
			case ($urandom_range(3))
				0, 1: it.address = 24'($urandom_range(span - 1));
				2: it.address = 24'(ROM_DEPTH - 8 + $urandom_range(15));
				default: ;
			endcase
		end else begin
			it.mode = MODE_UNUSED;
		end
		return it;
	endfunction

	// Offer one transaction and hold it until accepted. Entered on or after a
	// rising edge; valid stays high between back-to-back items and is only
	// lowered when the sender decides to idle.
	task automatic drive_item(input item_t it);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		due_replies = {due_replies, apply_access(it)};
	endtask

	// Send one item. A read that would reach a ROM byte never preloaded is
	// preceded by a preload of that byte, since such bytes are undefined.
	task automatic send_item(input item_t it);
		int unsigned idx;
		item_t fill;
		if (reads_rom_byte(it, idx) && !rom_image.exists(idx)) begin
			fill.mode = MODE_PRELOAD;
			fill.address = idx[23:0];
			fill.write_data = 8'($urandom);
			drive_item(fill);
		end
		drive_item(it);
	endtask

	// Stop offering and wait for every owed reply, then wait on until the block
	// is back at rest.
	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (due_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] reg_index,
			input logic [CFG_W-1:0] reg_value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= reg_index;
		cfg_data <= reg_value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (reg_index)
			CFG_LAYOUT: layout_cfg = reg_value[1:0];
			CFG_LOADED: loaded_cfg = reg_value[0];
			CFG_ROM_SIZE: rom_size_cfg = reg_value[22:0];
			CFG_SRAM_SIZE: sram_size_cfg = reg_value[17:0];
			default: ;
		endcase
	endtask

	// Registers only change with nothing in flight.
	task automatic configure(input logic [1:0] layout, input logic loaded,
			input logic [22:0] rom_bytes, input logic [17:0] sram_bytes);
		drain();
		write_reg(CFG_LAYOUT, CFG_W'(layout));
		write_reg(CFG_LOADED, CFG_W'(loaded));
		write_reg(CFG_ROM_SIZE, CFG_W'(rom_bytes));
		write_reg(CFG_SRAM_SIZE, CFG_W'(sram_bytes));
	endtask

	// Receiver: random stalls, or one long hold-off when the stimulus asks.
	always @(negedge clk) begin
		if (hold_off_seen != hold_off_asks) begin
			hold_off_seen <= hold_off_asks;
			hold_off_left <= HOLD_OFF_CYCLES;
			result_ready <= 1'b0;
		end else if (hold_off_left != 0) begin
			hold_off_left <= hold_off_left - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Compare each reply transaction with the oldest owed reply.
	always @(posedge clk) begin : check_replies
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (due_replies.size() == 0) begin
				$error("reply with nothing owed: read_data %0h target %0d",
					result.read_data, result.target);
				mismatch_count++;
			end else begin
				want = due_replies.pop_front();
				if (result.read_data !== want.read_data) begin
					$error("read_data: expected %0h, got %0h", want.read_data,
						result.read_data);
					mismatch_count++;
				end
				if (result.target !== want.target) begin
					$error("target: expected %0d, got %0d", want.target, result.target);
					mismatch_count++;
				end
			end
		end
	end

	// Registers at their reset values: no cartridge, so bus accesses decode to
	// nothing, while preloads still fill the ROM (or are ignored out of range).
	// These are offered while the RAM sweep is still running.
	task automatic test_no_cartridge();
		send_idle_pct = 37;
		recv_idle_pct = 81;
		send_item(bus_item(MODE_READ, 24'h700000, 8'h00));
		send_item(bus_item(MODE_WRITE, 24'h008000, 8'h3C));
		send_item(bus_item(MODE_PRELOAD, 24'h000000, 8'hA5));
		send_item(bus_item(MODE_PRELOAD, 24'(ROM_DEPTH - 1), 8'h5A));
		send_item(bus_item(MODE_PRELOAD, 24'hFFFFFF, 8'hFF));
		send_item(bus_item(MODE_UNUSED, 24'hFFFFFF, 8'hFF));
	endtask

	// Each layout, the spare code last: write the RAM window, read it back
	// through the mirrored bank, read a ROM corner and an unmapped address.
	task automatic test_layouts();
		logic [1:0] layout;
		for (int n = 0; n < 4; n++) begin
			layout = 2'(n);
			configure(layout, 1'b1, 23'h400000, 18'h20000);
			if (layout == LAYOUT_HIGH || layout == LAYOUT_EXT) begin
				send_item(bus_item(MODE_WRITE, 24'h3F6000, 8'h80 + 8'(n)));
				send_item(bus_item(MODE_READ, 24'hBF6000, 8'h00));
				send_item(bus_item(MODE_READ, 24'hC00000, 8'h00));
				send_item(bus_item(MODE_READ, 24'h7E0000, 8'h00));
			end else begin
				send_item(bus_item(MODE_WRITE, 24'h7D7FFF, 8'h40 + 8'(n)));
				send_item(bus_item(MODE_READ, 24'hFD7FFF, 8'h00));
				send_item(bus_item(MODE_READ, 24'h008000, 8'h00));
				send_item(bus_item(MODE_READ, 24'h3F0000, 8'h00));
			end
		end
	endtask

	// Zero sizes keep the window in target but read 0 and drop writes; sizes
	// past the store depths can wrap to indexes that read 0 and drop writes.
	task automatic test_empty_and_oversize();
		configure(LAYOUT_HIGH, 1'b1, 23'h0, 18'h0);
		send_item(bus_item(MODE_READ, 24'h206000, 8'h00));
		send_item(bus_item(MODE_WRITE, 24'h206000, 8'h77));
		send_item(bus_item(MODE_READ, 24'h008000, 8'h00));
		configure(LAYOUT_EXT, 1'b1, 23'h7FFFFF, 18'h3FFFF);
		send_item(bus_item(MODE_READ, 24'hC00000, 8'h00));
		send_item(bus_item(MODE_WRITE, 24'h3F6000, 8'hFF));
		send_item(bus_item(MODE_READ, 24'h3F6000, 8'h00));
		send_item(bus_item(MODE_READ, 24'h008000, 8'h00));
	endtask

	// The receiver holds off for a long stretch while the sender keeps
	// offering, so the block fills and drops item_ready; then the sender
	// waits for every reply before going on.
	task automatic test_backpressure();
		configure(LAYOUT_LOW, 1'b1, 23'h8000, 18'h800);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off_asks++;
		repeat (12) send_item(rand_item());
		drain();
	endtask

	// Random traffic over a range of register settings, repeated for each
	// idling pattern: receiver sparse, sender sparse, then no idling at all.
	task automatic test_random();
		for (int pass = 0; pass < 3; pass++) begin
			case (pass)
				0: begin send_idle_pct = 37; recv_idle_pct = 81; end
				1: begin send_idle_pct = 81; recv_idle_pct = 37; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			for (int setup = 0; setup < 8; setup++) begin
				case (setup)
					0: configure(LAYOUT_LOW, 1'b1, 23'h8000, 18'h800);
					1: configure(LAYOUT_HIGH, 1'b1, 23'h10000, 18'h2000);
					2: configure(LAYOUT_EXT, 1'b1, 23'h400000, 18'h20000);
					3: configure(LAYOUT_LOW_ALIAS, 1'b1, 23'h1234, 18'h7FF);
					4: configure(LAYOUT_EXT, 1'b1, 23'h7FFFFF, 18'h3FFFF);
					5: configure(LAYOUT_HIGH, 1'b0, 23'h1000, 18'h1000);
					6: configure(LAYOUT_LOW, 1'b1, 23'h0, 18'h0);
					default: configure(LAYOUT_HIGH, 1'b1, 23'h1, 18'h1);
				endcase
				repeat (ITEMS_PER_SETUP) send_item(rand_item());
			end
		end
	endtask

	initial begin
		foreach (sram_image[i])
			sram_image[i] = 8'h00;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_no_cartridge();
		test_layouts();
		test_empty_and_oversize();
		test_backpressure();
		test_random();
		drain();

		if (mismatch_count == 0)
			$display("rom_sram_bank_mapper_test passed");
		else
			$display("rom_sram_bank_mapper_test failed");
		$finish;
	end

endmodule
